### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define FLTW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fltw assertion failed");

// Checked on every edge, reset included.
`define FLTW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fltw assertion failed");

`endif

### hw/rtl/fltw_pkg.sv
package fltw_pkg;

    localparam int TABLE_WORDS = 4096;
    localparam int STORE_AW    = $clog2(TABLE_WORDS);

    localparam int PA_W    = 52;
    localparam int VA_W    = 64;
    localparam int WORD_W  = 64;
    localparam int WIDX_W  = 12;
    localparam int LEVEL_W = 3;
    localparam int FLAGS_W = 8;
    localparam int IDX_W   = 9;

    typedef enum logic [1:0] {
        CMD_TRANSLATE = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_READ      = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_MAPPED      = 3'd0,
        STAT_NOT_PRESENT = 3'd1,
        STAT_NON_CANON   = 3'd2,
        STAT_NO_ROOT     = 3'd3,
        STAT_OUTSIDE     = 3'd4,
        STAT_WORD_DONE   = 3'd5
    } t_status;

    // Entry bit positions.
    localparam int BIT_PRESENT = 0;
    localparam int BIT_RW      = 1;
    localparam int BIT_USER    = 2;
    localparam int BIT_PWT     = 3;
    localparam int BIT_PCD     = 4;
    localparam int BIT_HUGE    = 7;
    localparam int BIT_GLOBAL  = 8;
    localparam int BIT_NX      = 63;

    localparam int FLAG_LARGE2M = 7;

    function automatic logic [FLAGS_W-1:0] decode_flags(input logic [WORD_W-1:0] e);
        logic [FLAGS_W-1:0] f;
        f    = '0;
        f[0] = 1'b1;
        f[1] = e[BIT_RW];
        f[2] = ~e[BIT_NX];
        f[3] = e[BIT_USER];
        f[4] = e[BIT_PCD];
        f[5] = e[BIT_PCD] & e[BIT_PWT];
        f[6] = e[BIT_GLOBAL];
        return f;
    endfunction

endpackage

### hw/rtl/fltw_store.sv
module fltw_store
    import fltw_pkg::*;
(
    input  logic                i_clk,
    input  logic [STORE_AW-1:0] i_addr,
    input  logic                i_we,
    input  logic [WORD_W-1:0]   i_wdata,
    output logic [WORD_W-1:0]   o_rdata
);

    logic [WORD_W-1:0] r_mem [TABLE_WORDS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/four_level_page_table_walker.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_ready         i_command, i_virtual_address,
//                                                i_word_index, i_word_data
// result    out        o_valid / i_ready         o_status ... o_page_flags
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (root table address)
//
// A translation reads n table levels, n from 1 to 4, after the accept, decode and
// check steps and before the publish step; each level costs one address step and
// one step on the registered read of the single-port table store. A table that
// lies outside the store ends the walk at one more address step after the n levels
// read before it (n from 0 to 3). Checks that fail before any read go straight to
// publish; word writes and reads take a word step and a capture step.
// One word is in work at a time; the next word is taken once the result sits in
// the output register, and a stalled output holds the sequencer at its publish
// step. Reset is synchronous and clears the sequencer, output valid and root.
module four_level_page_table_walker
    import fltw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_command,
    input  logic [VA_W-1:0]     i_virtual_address,
    input  logic [WIDX_W-1:0]   i_word_index,
    input  logic [WORD_W-1:0]   i_word_data,

    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [LEVEL_W-1:0]  o_walk_level,
    output logic                o_is_large,
    output logic [PA_W-1:0]     o_entry_addr,
    output logic [WORD_W-1:0]   o_entry_raw,
    output logic [PA_W-1:0]     o_mapped_base,
    output logic [PA_W-1:0]     o_frame_address,
    output logic [FLAGS_W-1:0]  o_page_flags,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [PA_W-1:0]     i_cfg_data
);

    localparam int PC_W  = 3;
    localparam int SUM_W = PA_W - 3 + 1;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        A_ACCEPT,
        A_NONE,
        A_CHECK,
        A_ADDR,
        A_EVAL,
        A_PUBLISH,
        A_WORD,
        A_WCAP
    } t_act;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_WORD_CMD,
        C_FAULT,
        C_WALK_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   jump;
        t_pc   next;
    } t_uword;

    localparam t_pc PC_FETCH   = 3'd0;
    localparam t_pc PC_DECODE  = 3'd1;
    localparam t_pc PC_CHECK   = 3'd2;
    localparam t_pc PC_ADDR    = 3'd3;
    localparam t_pc PC_EVAL    = 3'd4;
    localparam t_pc PC_PUBLISH = 3'd5;
    localparam t_pc PC_WORD    = 3'd6;
    localparam t_pc PC_WCAP    = 3'd7;

    // The program: a conditional jump target and a fall-through step per word.
    function automatic t_uword ucode(input t_pc pc);
        t_uword u;
        u = '{act: A_NONE, cond: C_ALWAYS, jump: PC_FETCH, next: PC_FETCH};
        case (pc)
            PC_FETCH:   u = '{act: A_ACCEPT,  cond: C_NO_IN,     jump: PC_FETCH,
                              next: PC_DECODE};
            PC_DECODE:  u = '{act: A_NONE,    cond: C_WORD_CMD,  jump: PC_WORD,
                              next: PC_CHECK};
            PC_CHECK:   u = '{act: A_CHECK,   cond: C_FAULT,     jump: PC_PUBLISH,
                              next: PC_ADDR};
            PC_ADDR:    u = '{act: A_ADDR,    cond: C_FAULT,     jump: PC_PUBLISH,
                              next: PC_EVAL};
            PC_EVAL:    u = '{act: A_EVAL,    cond: C_WALK_MORE, jump: PC_ADDR,
                              next: PC_PUBLISH};
            PC_PUBLISH: u = '{act: A_PUBLISH, cond: C_OUT_BUSY,  jump: PC_PUBLISH,
                              next: PC_FETCH};
            PC_WORD:    u = '{act: A_WORD,    cond: C_NEVER,     jump: PC_FETCH,
                              next: PC_WCAP};
            PC_WCAP:    u = '{act: A_WCAP,    cond: C_NEVER,     jump: PC_FETCH,
                              next: PC_PUBLISH};
            default:    u = '{act: A_NONE,    cond: C_ALWAYS,    jump: PC_FETCH,
                              next: PC_FETCH};
        endcase
        return u;
    endfunction

    t_pc                r_pc;
    t_pc                n_pc;
    t_uword             w_uw;

    t_cmd               r_cmd;
    logic [VA_W-1:0]    r_va;
    logic [WIDX_W-1:0]  r_widx;
    logic [WORD_W-1:0]  r_wdata;
    logic [PA_W-1:0]    r_root;
    logic [PA_W-1:0]    r_table;
    logic [LEVEL_W-1:0] r_level;
    logic [PA_W-1:0]    r_eaddr;

    t_status            r_res_status;
    logic [LEVEL_W-1:0] r_res_level;
    logic               r_res_large;
    logic [PA_W-1:0]    r_res_eaddr;
    logic [WORD_W-1:0]  r_res_raw;
    logic [PA_W-1:0]    r_res_base;
    logic [PA_W-1:0]    r_res_frame;
    logic [FLAGS_W-1:0] r_res_flags;

    logic               r_out_valid;
    t_status            r_o_status;
    logic [LEVEL_W-1:0] r_o_level;
    logic               r_o_large;
    logic [PA_W-1:0]    r_o_eaddr;
    logic [WORD_W-1:0]  r_o_raw;
    logic [PA_W-1:0]    r_o_base;
    logic [PA_W-1:0]    r_o_frame;
    logic [FLAGS_W-1:0] r_o_flags;

    logic [IDX_W-1:0]    w_idx;
    logic [SUM_W-1:0]    w_word;
    logic                w_oob;
    logic [PA_W-1:0]     w_eaddr;
    logic                w_no_root;
    logic                w_canon;
    logic                w_widx_ok;
    logic                w_fault;
    logic                w_end;
    logic                w_cond;
    logic                w_out_load;
    logic [WORD_W-1:0]   w_e;
    logic [STORE_AW-1:0] w_mem_addr;
    logic                w_mem_we;
    logic [WORD_W-1:0]   w_store_rdata;

    assign w_uw = ucode(r_pc);

    // Table index for the level being walked.
    always_comb begin
        case (r_level)
            3'd4:    w_idx = r_va[47:39];
            3'd3:    w_idx = r_va[38:30];
            3'd2:    w_idx = r_va[29:21];
            default: w_idx = r_va[20:12];
        endcase
    end

    assign w_word    = SUM_W'(r_table[PA_W-1:3]) + SUM_W'(w_idx);
    assign w_oob     = (w_word >= SUM_W'(TABLE_WORDS));
    assign w_eaddr   = r_table + PA_W'({w_idx, 3'b000});
    assign w_no_root = (r_root == '0);
    assign w_canon   = (&r_va[VA_W-1:47]) | ~(|r_va[VA_W-1:47]);
    assign w_widx_ok = (32'(r_widx) < 32'(TABLE_WORDS));
    assign w_e       = w_store_rdata;

    // A walk ends at level 1, at a missing entry, or at a large leaf.
    assign w_end = (r_level == 3'd1) || !w_e[BIT_PRESENT]
                 || (((r_level == 3'd3) || (r_level == 3'd2)) && w_e[BIT_HUGE]);

    always_comb begin
        case (w_uw.act)
            A_CHECK: w_fault = w_no_root || !w_canon;
            A_ADDR:  w_fault = w_oob;
            default: w_fault = 1'b0;
        endcase
    end

    always_comb begin
        case (w_uw.cond)
            C_NEVER:     w_cond = 1'b0;
            C_ALWAYS:    w_cond = 1'b1;
            C_NO_IN:     w_cond = !i_valid;
            C_WORD_CMD:  w_cond = (r_cmd != CMD_TRANSLATE);
            C_FAULT:     w_cond = w_fault;
            C_WALK_MORE: w_cond = !w_end;
            C_OUT_BUSY:  w_cond = r_out_valid && !i_ready;
            default:     w_cond = 1'b0;
        endcase
    end

    assign n_pc       = w_cond ? w_uw.jump : w_uw.next;
    assign w_out_load = (w_uw.act == A_PUBLISH) && (!r_out_valid || i_ready);

    assign w_mem_addr = (w_uw.act == A_WORD) ? STORE_AW'(r_widx) : w_word[STORE_AW-1:0];
    assign w_mem_we   = (w_uw.act == A_WORD) && (r_cmd == CMD_WRITE) && w_widx_ok;

    fltw_store u_store (
        .i_clk   (i_clk),
        .i_addr  (w_mem_addr),
        .i_we    (w_mem_we),
        .i_wdata (r_wdata),
        .o_rdata (w_store_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_FETCH;
            r_out_valid <= 1'b0;
            r_root      <= '0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_valid) begin
                r_root <= i_cfg_data;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (w_uw.act)
                A_ACCEPT: begin
                    if (i_valid) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_va    <= i_virtual_address;
                        r_widx  <= i_word_index;
                        r_wdata <= i_word_data;
                    end
                end
                A_CHECK: begin
                    // A missing root wins over a non-canonical address.
                    r_res_status <= w_no_root ? STAT_NO_ROOT
                                  : (!w_canon ? STAT_NON_CANON : STAT_MAPPED);
                    r_res_level  <= '0;
                    r_res_large  <= 1'b0;
                    r_res_eaddr  <= '0;
                    r_res_raw    <= '0;
                    r_res_base   <= '0;
                    r_res_frame  <= '0;
                    r_res_flags  <= '0;
                    r_level      <= 3'd4;
                    r_table      <= {r_root[PA_W-1:12], 12'b0};
                end
                A_ADDR: begin
                    r_eaddr <= w_eaddr;
                    if (w_oob) begin
                        r_res_status <= STAT_OUTSIDE;
                        r_res_level  <= r_level;
                    end
                end
                A_EVAL: begin
                    if (r_level == 3'd1) begin
                        r_res_status <= w_e[BIT_PRESENT] ? STAT_MAPPED : STAT_NOT_PRESENT;
                        r_res_level  <= r_level;
                        r_res_eaddr  <= r_eaddr;
                        r_res_raw    <= w_e;
                        r_res_base   <= {w_e[PA_W-1:12], 12'b0};
                        if (w_e[BIT_PRESENT]) begin
                            r_res_frame <= {w_e[PA_W-1:12], 12'b0};
                            r_res_flags <= decode_flags(w_e);
                        end
                    end else if (!w_e[BIT_PRESENT]) begin
                        r_res_status <= STAT_NOT_PRESENT;
                        r_res_level  <= r_level;
                    end else if (w_end) begin
                        r_res_status <= STAT_MAPPED;
                        r_res_level  <= r_level;
                        r_res_large  <= 1'b1;
                        r_res_eaddr  <= r_eaddr;
                        r_res_raw    <= w_e;
                        if (r_level == 3'd3) begin
                            r_res_base  <= {w_e[PA_W-1:30], 30'b0};
                            r_res_frame <= {w_e[PA_W-1:30], 30'b0};
                            r_res_flags <= decode_flags(w_e);
                        end else begin
                            // The 4 KiB index fills the low bits a 2 MiB base leaves clear.
                            r_res_base  <= {w_e[PA_W-1:21], 21'b0};
                            r_res_frame <= {w_e[PA_W-1:21], r_va[20:12], 12'b0};
                            r_res_flags <= decode_flags(w_e)
                                         | FLAGS_W'(1 << FLAG_LARGE2M);
                        end
                    end else begin
                        r_table <= {w_e[PA_W-1:12], 12'b0};
                        r_level <= r_level - 3'd1;
                    end
                end
                A_WCAP: begin
                    r_res_status <= STAT_WORD_DONE;
                    r_res_level  <= '0;
                    r_res_large  <= 1'b0;
                    r_res_eaddr  <= '0;
                    r_res_raw    <= ((r_cmd == CMD_READ) && w_widx_ok) ? w_e : '0;
                    r_res_base   <= '0;
                    r_res_frame  <= '0;
                    r_res_flags  <= '0;
                end
                A_PUBLISH: begin
                    if (w_out_load) begin
                        r_o_status  <= r_res_status;
                        r_o_level   <= r_res_level;
                        r_o_large   <= r_res_large;
                        r_o_eaddr   <= r_res_eaddr;
                        r_o_raw     <= r_res_raw;
                        r_o_base    <= r_res_base;
                        r_o_frame   <= r_res_frame;
                        r_o_flags   <= r_res_flags;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ready         = (w_uw.act == A_ACCEPT);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_status        = r_o_status;
    assign o_walk_level    = r_o_level;
    assign o_is_large      = r_o_large;
    assign o_entry_addr    = r_o_eaddr;
    assign o_entry_raw     = r_o_raw;
    assign o_mapped_base   = r_o_base;
    assign o_frame_address = r_o_frame;
    assign o_page_flags    = r_o_flags;

endmodule

### hw/rtl/fltw_checker.sv
`include "assert_macros.svh"

module fltw_checker
    import fltw_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic [2:0]          o_status,
    input logic [LEVEL_W-1:0]  o_walk_level,
    input logic                o_is_large,
    input logic [PA_W-1:0]     o_frame_address
);

    // A result word waiting on the consumer stays put.
    `FLTW_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_status))

    // Large leaves only come from a successful walk ending at level 3 or 2.
    `FLTW_ASSERT(a_large_leaf, i_clk, i_rst_n, o_valid && o_is_large |-> o_status == STAT_MAPPED && (o_walk_level == 3'd3 || o_walk_level == 3'd2))

    // Word accesses carry no walk information.
    `FLTW_ASSERT(a_word_clean, i_clk, i_rst_n, o_valid && o_status == STAT_WORD_DONE |-> o_walk_level == '0 && !o_is_large && o_frame_address == '0)

    // Nothing is offered in the cycle after reset.
    `FLTW_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind four_level_page_table_walker fltw_checker u_fltw_checker (.*);

### tb/tb_four_level_page_table_walker.sv
module tb_four_level_page_table_walker;
    import fltw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 3000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        t_status            status;
        logic [LEVEL_W-1:0] level;
        logic               is_large;
        logic [PA_W-1:0]    entry_addr;
        logic [WORD_W-1:0]  entry_raw;
        logic [PA_W-1:0]    mapped_base;
        logic [PA_W-1:0]    frame;
        logic [FLAGS_W-1:0] flags;
    } t_walk_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_command;
    logic [VA_W-1:0]     i_virtual_address;
    logic [WIDX_W-1:0]   i_word_index;
    logic [WORD_W-1:0]   i_word_data;
    logic                o_valid;
    logic                i_ready;
    logic [2:0]          o_status;
    logic [LEVEL_W-1:0]  o_walk_level;
    logic                o_is_large;
    logic [PA_W-1:0]     o_entry_addr;
    logic [WORD_W-1:0]   o_entry_raw;
    logic [PA_W-1:0]     o_mapped_base;
    logic [PA_W-1:0]     o_frame_address;
    logic [FLAGS_W-1:0]  o_page_flags;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [PA_W-1:0]     i_cfg_data;

    // Shadow of the block: table words, which of them hold data, and the root.
    logic [WORD_W-1:0]   table_mem [TABLE_WORDS];
    bit                  written [TABLE_WORDS];
    int                  written_list [$];
    logic [PA_W-1:0]     root_reg;

    t_walk_result        pending_results [$];
    int                  fail_count;
    int                  mismatch_count;
    int                  words_sent;
    int                  snd_idle_pct;
    int                  rx_idle_pct;
    bit                  rx_hold_req;
    int                  stall_cycles;

    four_level_page_table_walker dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_command         (i_command),
        .i_virtual_address (i_virtual_address),
        .i_word_index      (i_word_index),
        .i_word_data       (i_word_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_walk_level      (o_walk_level),
        .o_is_large        (o_is_large),
        .o_entry_addr      (o_entry_addr),
        .o_entry_raw       (o_entry_raw),
        .o_mapped_base     (o_mapped_base),
        .o_frame_address   (o_frame_address),
        .o_page_flags      (o_page_flags),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [FLAGS_W-1:0] access_flags(input logic [WORD_W-1:0] ent);
        return {1'b0, ent[BIT_GLOBAL], ent[BIT_PCD] & ent[BIT_PWT], ent[BIT_PCD],
                ent[BIT_USER], ~ent[BIT_NX], ent[BIT_RW], 1'b1};
    endfunction

    // Frame bits of an entry, cleared below the page size of its level.
    function automatic logic [PA_W-1:0] page_base(input logic [WORD_W-1:0] ent, input int lvl);
        case (lvl)
            3:       return {ent[PA_W-1:30], 30'h0};
            2:       return {ent[PA_W-1:21], 21'h0};
            default: return {ent[PA_W-1:12], 12'h0};
        endcase
    endfunction

    // Walks the shadow tables. A word the walk would read but that was never
    // written is reported as a hole so that it can be filled before sending.
    function automatic t_walk_result walk_table(input logic [VA_W-1:0] va,
                                                output int hole_word, output int hole_lvl);
        t_walk_result     r;
        logic [PA_W-1:0]  tbl;
        logic [IDX_W-1:0] vidx;
        logic [63:0]      word_no;
        logic [WORD_W-1:0] ent;
        r         = '0;
        hole_word = -1;
        hole_lvl  = 0;
        if (root_reg == '0) begin
            r.status = STAT_NO_ROOT;
            return r;
        end
        if (va[63:47] != '0 && va[63:47] != '1) begin
            r.status = STAT_NON_CANON;
            return r;
        end
        tbl = {root_reg[PA_W-1:12], 12'h0};
        for (int lvl = 4; lvl >= 1; lvl--) begin
            vidx    = va[12 + 9 * (lvl - 1) +: 9];
            word_no = (64'(tbl) >> 3) + 64'(vidx);
            r.level = LEVEL_W'(lvl);
            if (word_no >= TABLE_WORDS) begin
                r.status = STAT_OUTSIDE;
                return r;
            end
            if (!written[word_no]) begin
                hole_word = int'(word_no);
                hole_lvl  = lvl;
                return r;
            end
            ent = table_mem[word_no];
            if (lvl == 1) begin
                r.entry_addr  = tbl + PA_W'({vidx, 3'b000});
                r.entry_raw   = ent;
                r.mapped_base = page_base(ent, 1);
                if (ent[BIT_PRESENT]) begin
                    r.status = STAT_MAPPED;
                    r.frame  = r.mapped_base;
                    r.flags  = access_flags(ent);
                end else begin
                    r.status = STAT_NOT_PRESENT;
                end
                return r;
            end
            if (!ent[BIT_PRESENT]) begin
                r.status = STAT_NOT_PRESENT;
                return r;
            end
            if ((lvl == 3 || lvl == 2) && ent[BIT_HUGE]) begin
                r.status      = STAT_MAPPED;
                r.is_large    = 1'b1;
                r.entry_addr  = tbl + PA_W'({vidx, 3'b000});
                r.entry_raw   = ent;
                r.mapped_base = page_base(ent, lvl);
                r.frame       = r.mapped_base;
                r.flags       = access_flags(ent);
                if (lvl == 2) begin
                    // Only the 2 MiB leaf adds the 4 KiB index to its frame.
                    r.frame = r.mapped_base + PA_W'({va[20:12], 12'h0});
                    r.flags[FLAG_LARGE2M] = 1'b1;
                end
                return r;
            end
            tbl = {ent[PA_W-1:12], 12'h0};
        end
        return r;
    endfunction

    function automatic t_walk_result resolve_word(input t_cmd cmd, input logic [VA_W-1:0] va,
                                                  input logic [WIDX_W-1:0] widx,
                                                  input logic [WORD_W-1:0] wdata);
        t_walk_result r;
        int           hw;
        int           hl;
        r = '0;
        case (cmd)
            CMD_TRANSLATE: begin
                r = walk_table(va, hw, hl);
            end
            CMD_WRITE: begin
                r.status        = STAT_WORD_DONE;
                table_mem[widx] = wdata;
                if (!written[widx]) begin
                    written[widx] = 1'b1;
                    written_list.push_back(int'(widx));
                end
            end
            CMD_READ: begin
                r.status    = STAT_WORD_DONE;
                r.entry_raw = table_mem[widx];
            end
            default: begin
                r.status = STAT_WORD_DONE;
            end
        endcase
        return r;
    endfunction

    // Random table entry for a level, mostly present; an entry that points at a lower
    // table mostly points at one of the pages inside the store.
    function automatic logic [WORD_W-1:0] make_entry(input int lvl);
        logic [WORD_W-1:0] e;
        e = rand64();
        e[BIT_PRESENT] = ($urandom_range(0, 99) >= 12);
        if (lvl == 3 || lvl == 2)
            e[BIT_HUGE] = ($urandom_range(0, 99) < 25);
        if ((lvl == 4 || (lvl > 1 && !e[BIT_HUGE])) && $urandom_range(0, 99) >= 6)
            e[PA_W-1:12] = 40'($urandom_range(0, 7));
        return e;
    endfunction

    function automatic logic [VA_W-1:0] gen_va();
        logic [VA_W-1:0] va;
        va = rand64();
        for (int l = 0; l < 4; l++) begin
            if ($urandom_range(0, 99) < 40)
                va[12 + 9 * l +: 9] = IDX_W'($urandom_range(0, 3));
        end
        va[63:48] = {16{va[47]}};
        return va;
    endfunction

    task automatic send_word(input t_cmd cmd, input logic [VA_W-1:0] va,
                             input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] wdata);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_command         <= cmd;
        i_virtual_address <= va;
        i_word_index      <= widx;
        i_word_data       <= wdata;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(resolve_word(cmd, va, widx, wdata));
        words_sent++;
    endtask

    task automatic put_word(input int idx, input logic [WORD_W-1:0] data);
        send_word(CMD_WRITE, rand64(), WIDX_W'(idx), data);
    endtask

    task automatic translate(input logic [VA_W-1:0] va);
        send_word(CMD_TRANSLATE, va, WIDX_W'($urandom), rand64());
    endtask

    // Fills every table word the walk would hit unwritten, then translates.
    task automatic send_translation(input logic [VA_W-1:0] va);
        t_walk_result probe;
        int           hole_word;
        int           hole_lvl;
        probe = walk_table(va, hole_word, hole_lvl);
        while (hole_word >= 0) begin
            put_word(hole_word, make_entry(hole_lvl));
            probe = walk_table(va, hole_word, hole_lvl);
        end
        translate(va);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [PA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        root_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            send_translation(gen_va());
        end else if (pick < 58) begin
            send_translation(rand64());
        end else if (pick < 75) begin
            put_word(int'($urandom_range(0, TABLE_WORDS - 1)),
                     ($urandom_range(0, 1) != 0) ? rand64() : make_entry($urandom_range(1, 4)));
        end else if (pick < 92) begin
            if (written_list.size() != 0)
                send_word(CMD_READ, rand64(),
                          WIDX_W'(written_list[$urandom_range(0, written_list.size() - 1)]),
                          rand64());
        end else begin
            send_word(CMD_NONE, rand64(), WIDX_W'($urandom), rand64());
        end
    endtask

    task automatic test_no_root();
        write_root('0);
        translate(64'h0000_1234_5678_9000);
        translate(64'h8000_0000_0000_0000);
    endtask

    task automatic test_word_access();
        put_word(0, 64'h0);
        put_word(TABLE_WORDS - 1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_READ, rand64(), WIDX_W'(0), rand64());
        send_word(CMD_READ, rand64(), WIDX_W'(TABLE_WORDS - 1), rand64());
        send_word(CMD_NONE, rand64(), WIDX_W'(0), rand64());
    endtask

    // Root table at 0x1000, then 0x2000, 0x3000 and 0x4000 for the lower levels.
    task automatic test_directed_walks();
        drain();
        write_root(52'h1ABC);
        put_word(512,  64'h0000_0000_0000_2003);
        put_word(1024, 64'h0000_0000_0000_3007);
        put_word(1536, 64'h0000_0000_0000_4027);
        put_word(2048, 64'h800F_FFFF_FFFF_F11F);
        put_word(2049, 64'h0000_0ABC_DEF0_1FFE);
        put_word(1537, 64'h0000_0001_2345_6083);
        put_word(1025, 64'h7FF0_0007_FFFF_F087);
        put_word(1026, 64'hFFFF_FFFF_FFFF_FFFE);
        put_word(1538, 64'h0);
        put_word(513,  64'h0000_0000_0000_9001);
        put_word(514,  64'h0000_0000_0000_2000);
        put_word(1023, 64'h8000_0000_0000_2001);
        translate(64'h0000_0000_0000_0FFF);
        translate(64'h0000_0000_0000_1000);
        translate(64'h0000_0000_003F_FABC);
        translate(64'h0000_0000_4001_2345);
        translate(64'h0000_0000_8000_0000);
        translate(64'h0000_0000_0040_0000);
        translate(64'h0000_0080_0000_0000);
        translate(64'h0000_0100_0000_0000);
        translate(64'hFFFF_FF80_0000_0000);
        translate(64'h0000_8000_0000_0000);
        translate(64'hFFFF_7FFF_FFFF_FFFF);
    endtask

    task automatic test_root_extremes();
        drain();
        write_root(52'hF_FFFF_FFFF_FFFF);
        translate(64'h0);
    endtask

    task automatic test_random_traffic(input int count, input logic [PA_W-1:0] root);
        int start;
        drain();
        write_root(root);
        start = words_sent;
        while (words_sent - start < count) send_random_item();
    endtask

    // The receiver stops for a long stretch while words keep coming, so the
    // block fills up and holds its input; then the sender waits for all results and sends ten random items.
    task automatic test_output_stall();
        drain();
        @(posedge i_clk);
        rx_hold_req = 1'b1;
        repeat (12) send_translation(gen_va());
        drain();
        repeat (10) send_random_item();
    endtask

    initial begin : rx_drive
        int hold_left;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                hold_left   = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_walk_result got;
        t_walk_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.status      = t_status'(o_status);
            got.level       = o_walk_level;
            got.is_large    = o_is_large;
            got.entry_addr  = o_entry_addr;
            got.entry_raw   = o_entry_raw;
            got.mapped_base = o_mapped_base;
            got.frame       = o_frame_address;
            got.flags       = o_page_flags;
            if (pending_results.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word: status %0d level %0d raw %h",
                             got.status, got.level, got.entry_raw);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch (expected/actual): status %0d/%0d level %0d/%0d",
                                 want.status, got.status, want.level, got.level);
                        $display("  large %0d/%0d entry_addr %h/%h raw %h/%h",
                                 want.is_large, got.is_large, want.entry_addr,
                                 got.entry_addr, want.entry_raw, got.entry_raw);
                        $display("  base %h/%h frame %h/%h flags %h/%h",
                                 want.mapped_base, got.mapped_base, want.frame, got.frame,
                                 want.flags, got.flags);
                    end
                end
            end
        end
    end

    // Ends the run when nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_four_level_page_table_walker NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_command         = CMD_NONE;
        i_virtual_address = '0;
        i_word_index      = '0;
        i_word_data       = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = '0;
        root_reg          = '0;
        fail_count        = 0;
        mismatch_count    = 0;
        words_sent        = 0;
        stall_cycles      = 0;
        rx_hold_req       = 1'b0;
        snd_idle_pct      = 26;
        rx_idle_pct       = 45;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_no_root();
        test_word_access();
        test_directed_walks();
        test_root_extremes();
        test_random_traffic(150, {40'($urandom_range(1, 7)), 12'($urandom)});

        snd_idle_pct = 45;
        rx_idle_pct  = 26;
        test_random_traffic(150, 52'hFFF);

        snd_idle_pct = 0;
        rx_idle_pct  = 0;
        test_random_traffic(150, {40'($urandom_range(0, 7)), 12'($urandom_range(1, 4095))});
        test_output_stall();

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_four_level_page_table_walker OK");
        else
            $display("tb_four_level_page_table_walker NOT OK");
        $finish;
    end

endmodule
